// ===== hdl/convex_polygon_support_point_top_assert.svh =====
// Assertion macros for the convex polygon support point block.
`ifndef CONVEX_POLYGON_SUPPORT_POINT_TOP_ASSERT_SVH
`define CONVEX_POLYGON_SUPPORT_POINT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CPSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CPSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CPSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/cpsp_pkg.sv =====
// Shared types, constants and helpers of the support point block.
package cpsp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int LVL_W            = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_COS = 3'd0,
    REG_ROT_SIN = 3'd1,
    REG_SCALE_X = 3'd2,
    REG_SCALE_Y = 3'd3,
    REG_VEL_X   = 3'd4,
    REG_VEL_Y   = 3'd5,
    REG_START_X = 3'd6,
    REG_START_Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [17:0] rot_cos;
    logic [17:0] rot_sin;
    logic [31:0] scale_x;
    logic [31:0] scale_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] start_x;
    logic [31:0] start_y;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    rot_cos: 18'd65536,
    rot_sin: 18'd0,
    scale_x: 32'd65536,
    scale_y: 32'd65536,
    vel_x:   32'd0,
    vel_y:   32'd0,
    start_x: 32'd0,
    start_y: 32'd0
  };

  // a/b carry the vertex for loads and the direction for queries
  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_if_t;

  typedef struct packed {
    logic             full;
    logic [LVL_W-1:0] level;
  } front_stat_t;

  typedef struct packed {
    logic in_query;
    logic running;
  } back_stat_t;

  // clamp a wide signed value into Q16.16
  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    logic [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/cpsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cpsp_front.sv =====
// Front end: takes command beats, classifies them and queues them for the back end.
module cpsp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             op,
  input  logic [31:0]            vertex_x,
  input  logic [31:0]            vertex_y,
  input  logic [31:0]            dir_x,
  input  logic [31:0]            dir_y,
  input  logic                   pop,
  output cpsp_pkg::q_if_t        q,
  output cpsp_pkg::front_stat_t  stat
);
  import cpsp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  cmd_t             incoming;
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [LVL_W-1:0] level;
  logic             full;
  logic             push;

  always_comb begin
    incoming.op = op_t'(op);
    unique case (incoming.op)
      OP_LOAD: begin
        incoming.a = vertex_x;
        incoming.b = vertex_y;
      end
      OP_QUERY: begin
        incoming.a = dir_x;
        incoming.b = dir_y;
      end
      OP_TICK, OP_CLEAR: begin
        incoming.a = '0;
        incoming.b = '0;
      end
    endcase
  end

  assign full = (level == LVL_W'(QUEUE_DEPTH));
  assign push = start && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= incoming;
    end
  end

  assign q.valid    = (level != '0);
  assign q.cmd      = slots[rptr];
  assign stat.full  = full;
  assign stat.level = level;

endmodule

// ===== hdl/cpsp_back.sv =====
// Back end: vertex store, position, and the pipelined support point search.
module cpsp_back #(
  parameter int MAX_VERTICES = cpsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cpsp_pkg::cfg_t       cfg,
  input  cpsp_pkg::q_if_t      q,
  output logic                 pop,
  output cpsp_pkg::back_stat_t stat,
  output logic                 done,
  output logic [31:0]          support_x,
  output logic [31:0]          support_y,
  output logic [3:0]           support_index,
  output logic                 empty_res
);
  import cpsp_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  typedef struct packed {
    logic          first;
    logic          last;
    logic [IW-1:0] idx;
  } tag_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [31:0]   pos_x;
  logic [31:0]   pos_y;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;

  logic          ram_we;
  logic [63:0]   ram_rdata;
  logic          last_issue;

  // config as signed operands
  logic signed [17:0] rot_cos;
  logic signed [17:0] rot_sin;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;

  // pipeline
  logic v1, v2, v3, v4, v5, v6;
  tag_t t1, t2, t3, t4, t5, t6;
  logic signed [31:0] mx, my;
  logic signed [63:0] px, py;
  logic signed [31:0] sx, sy;
  logic signed [49:0] cxs, sys, sxs, cys;
  logic signed [50:0] rx_diff, ry_sum;
  logic signed [34:0] rx, ry;
  logic signed [47:0] wx_wide, wy_wide;
  logic signed [31:0] wx4, wy4;
  logic signed [63:0] ex, ey;
  logic [31:0]        wx5, wy5, wx6, wy6;
  logic signed [64:0] dot6;
  logic signed [64:0] best_dot;
  logic [31:0]        best_x, best_y;
  logic [IW-1:0]      best_idx;
  logic               take;

  assign rot_cos = cfg.rot_cos;
  assign rot_sin = cfg.rot_sin;
  assign scale_x = cfg.scale_x;
  assign scale_y = cfg.scale_y;

  assign pop        = (state == S_IDLE) && q.valid;
  assign ram_we     = pop && (q.cmd.op == OP_LOAD) && (count < CW'(MAX_VERTICES));
  assign last_issue = ((CW'(idx) + CW'(1)) == count);

  cpsp_ram #(
    .WIDTH (64),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata ({q.cmd.b, q.cmd.a}),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign mx = ram_rdata[31:0];
  assign my = ram_rdata[63:32];

  // stage 2: scale result, floor shift, clamp
  assign sx = sat32(px[63:16]);
  assign sy = sat32(py[63:16]);

  // stage 3: rotate, translate, clamp
  assign rx_diff = cxs - sys;
  assign ry_sum  = sxs + cys;
  assign rx      = rx_diff[50:16];
  assign ry      = ry_sum[50:16];
  assign wx_wide = rx + $signed(pos_x);
  assign wy_wide = ry + $signed(pos_y);

  // stage 6: first strictly greater dot wins
  assign take = t6.first || (dot6 > best_dot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      idx           <= '0;
      pos_x         <= CFG_RST.start_x;
      pos_y         <= CFG_RST.start_y;
      done          <= 1'b0;
      empty_res     <= 1'b0;
      support_x     <= '0;
      support_y     <= '0;
      support_index <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (q.cmd.op)
              OP_LOAD: begin
                if (count < CW'(MAX_VERTICES)) begin
                  count <= count + CW'(1);
                end
              end
              OP_TICK: begin
                pos_x <= pos_x + cfg.vel_x;
                pos_y <= pos_y + cfg.vel_y;
              end
              OP_CLEAR: begin
                count <= '0;
                pos_x <= cfg.start_x;
                pos_y <= cfg.start_y;
              end
              OP_QUERY: begin
                if (count == '0) begin
                  done          <= 1'b1;
                  empty_res     <= 1'b1;
                  support_x     <= '0;
                  support_y     <= '0;
                  support_index <= '0;
                end else begin
                  dir_x <= q.cmd.a;
                  dir_y <= q.cmd.b;
                  idx   <= '0;
                  state <= S_RUN;
                end
              end
            endcase
          end
        end
        S_RUN: begin
          idx <= idx + IW'(1);
          if (last_issue) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (v6 && t6.last) begin
            done          <= 1'b1;
            empty_res     <= 1'b0;
            support_x     <= take ? wx6 : best_x;
            support_y     <= take ? wy6 : best_y;
            support_index <= 4'(take ? t6.idx : best_idx);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // valid/tag shift
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    t1       <= '{first: (idx == '0), last: last_issue, idx: idx};
    t2       <= t1;
    t3       <= t2;
    t4       <= t3;
    t5       <= t4;
    t6       <= t5;
    px       <= scale_x * mx;
    py       <= scale_y * my;
    cxs      <= rot_cos * sx;
    sys      <= rot_sin * sy;
    sxs      <= rot_sin * sx;
    cys      <= rot_cos * sy;
    wx4      <= sat32(wx_wide);
    wy4      <= sat32(wy_wide);
    ex       <= dir_x * wx4;
    ey       <= dir_y * wy4;
    wx5      <= wx4;
    wy5      <= wy4;
    dot6     <= ex + ey;
    wx6      <= wx5;
    wy6      <= wy5;
    if (v6 && take) begin
      best_dot <= dot6;
      best_x   <= wx6;
      best_y   <= wy6;
      best_idx <= t6.idx;
    end
  end

  assign stat.in_query = (state != S_IDLE) || (pop && (q.cmd.op == OP_QUERY));
  assign stat.running  = (state == S_RUN);

endmodule

// ===== hdl/convex_polygon_support_point_top.sv =====
// Top level of the convex polygon support point block: config registers, front and back end.
//
// Commands (load vertex, tick, support query, clear) are taken one beat per cycle
// whenever busy is low; busy only rises when the two-entry command queue is full.
// The back end drains the queue in order: load, tick and clear are applied as
// they are popped. A query walks the stored vertices through a six-stage
// transform and dot product pipeline, one vertex issued per cycle from the
// vertex RAM read port; an empty store gives an empty result without entering
// the pipeline. The result beat is one cycle of done with the payload beside
// it; the receiver cannot stall it, so sample it then. Config writes are
// registered and should be made while no command is queued or in flight;
// start_x and start_y only take effect at the next clear, as reset loads the
// default start position.
module convex_polygon_support_point_top #(
  parameter int MAX_VERTICES = cpsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [31:0]                    vertex_x,
  input  logic [31:0]                    vertex_y,
  input  logic [31:0]                    dir_x,
  input  logic [31:0]                    dir_y,
  // result side
  output logic                           done,
  output logic [31:0]                    support_x,
  output logic [31:0]                    support_y,
  output logic [3:0]                     support_index,
  output logic                           empty_res,
  // config write port
  input  logic                           cfg_we,
  input  logic [cpsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpsp_pkg::*;

`include "convex_polygon_support_point_top_assert.svh"

  cfg_t        cfg;
  q_if_t       q;
  logic        pop;
  front_stat_t fstat;
  back_stat_t  bstat;

  // config registers, every index is a real register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROT_COS: cfg.rot_cos <= cfg_data[17:0];
        REG_ROT_SIN: cfg.rot_sin <= cfg_data[17:0];
        REG_SCALE_X: cfg.scale_x <= cfg_data;
        REG_SCALE_Y: cfg.scale_y <= cfg_data;
        REG_VEL_X:   cfg.vel_x   <= cfg_data;
        REG_VEL_Y:   cfg.vel_y   <= cfg_data;
        REG_START_X: cfg.start_x <= cfg_data;
        REG_START_Y: cfg.start_y <= cfg_data;
      endcase
    end
  end

  cpsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .pop      (pop),
    .q        (q),
    .stat     (fstat)
  );

  cpsp_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q             (q),
    .pop           (pop),
    .stat          (bstat),
    .done          (done),
    .support_x     (support_x),
    .support_y     (support_y),
    .support_index (support_index),
    .empty_res     (empty_res)
  );

  assign busy = fstat.full;

  // empty result carries zero payload
  `CPSP_ASSERT_IMP(a_empty_zero, clk, rst, done && empty_res, support_x == 32'd0 && support_y == 32'd0 && support_index == 4'd0, "empty result with nonzero payload")
  // a result beat only follows query work in the back end
  `CPSP_ASSERT_IMP(a_done_from_query, clk, rst, done, $past(bstat.in_query), "result beat without a query")
  // an accepted beat that is not drained grows the queue by one
  `CPSP_ASSERT_NXT(a_queue_grow, clk, rst, start && !busy && !pop, fstat.level == $past(fstat.level) + 1'b1, "queue level lost a beat")

endmodule
